### rtl/core/hmf_pkg.sv
// hmf_pkg: shared types, constants and helpers for the http1 message framer
// no dependencies
package hmf_pkg;

    localparam int COUNT_WIDTH = 40;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'd0,
        PH_START  = 4'd1,
        PH_HBEGIN = 4'd2,
        PH_HNAME  = 4'd3,
        PH_HCOLON = 4'd4,
        PH_HVALUE = 4'd5,
        PH_BODY   = 4'd6,
        PH_CSIZE  = 4'd7,
        PH_CDATA  = 4'd8,
        PH_CDEND  = 4'd9,
        PH_CTAIL  = 4'd10,
        PH_IGNORE = 4'd11
    } t_phase;

    localparam logic [3:0] K_SKIP   = 4'd0;
    localparam logic [3:0] K_FIRST  = 4'd1;
    localparam logic [3:0] K_SECOND = 4'd2;
    localparam logic [3:0] K_QUERY  = 4'd3;
    localparam logic [3:0] K_THIRD  = 4'd4;
    localparam logic [3:0] K_HNAME  = 4'd5;
    localparam logic [3:0] K_HVALUE = 4'd6;
    localparam logic [3:0] K_BODY   = 4'd7;
    localparam logic [3:0] K_CHUNK  = 4'd8;

    localparam logic [4:0] LEN_CL = 5'd14;
    localparam logic [4:0] LEN_TE = 5'd17;
    localparam logic [4:0] LEN_TR = 5'd7;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  out_byte;
        logic        is_response;
        logic [9:0]  status_code;
        logic [39:0] body_count;
        logic        message_done;
        logic        error_flag;
    } t_result;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SP || b == 8'd9 || b == 8'd11 || b == 8'd12;
    endfunction

    // 16 means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] l;
        l = to_lower(b);
        if (is_digit(b)) return {1'b0, b[3:0]};
        if (l >= "a" && l <= "f") return 5'(l - "a" + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] c, input logic [4:0] p);
        logic [7:0] r;
        r = 8'd0;
        unique case (c)
            2'd0: unique case (p)
                5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t";
                5'd4: r = "e"; 5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-";
                5'd8: r = "l"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "g";
                5'd12: r = "t"; 5'd13: r = "h";
                default: r = 8'd0;
            endcase
            2'd1: unique case (p)
                5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "n";
                5'd4: r = "s"; 5'd5: r = "f"; 5'd6: r = "e"; 5'd7: r = "r";
                5'd8: r = "-"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "c";
                5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
                5'd16: r = "g";
                default: r = 8'd0;
            endcase
            2'd2: unique case (p)
                5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "i";
                5'd4: r = "l"; 5'd5: r = "e"; 5'd6: r = "r";
                default: r = 8'd0;
            endcase
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] chunked_char(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "c"; 4'd1: r = "h"; 4'd2: r = "u"; 4'd3: r = "n";
            4'd4: r = "k"; 4'd5: r = "e"; 4'd6: r = "d";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] http_char(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "H"; 4'd1: r = "T"; 4'd2: r = "T"; 4'd3: r = "P";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/hmf_mul_acc.sv
// hmf_mul_acc: saturating decimal or hex digit accumulate for counters
// depends on hmf_pkg
module hmf_mul_acc (
    input  logic [hmf_pkg::COUNT_WIDTH-1:0] i_acc,
    input  logic                            i_hex,
    input  logic [3:0]                      i_digit,
    output logic [hmf_pkg::COUNT_WIDTH-1:0] o_acc
);
    localparam int W = hmf_pkg::COUNT_WIDTH;
    logic [W+4:0] prod;
    always_comb begin
        // times 10 is x8 + x2, times 16 a shift
        if (i_hex) prod = {1'b0, i_acc, 4'b0} + (W+5)'(i_digit);
        else prod = {2'b0, i_acc, 3'b0} + {4'b0, i_acc, 1'b0} + (W+5)'(i_digit);
        o_acc = (prod[W+4:W] != '0) ? hmf_pkg::CNT_MAX : prod[W-1:0];
    end
endmodule

### rtl/core/hmf_parser.sv
// hmf_parser: per-byte parse state and result computation
// depends on hmf_pkg, hmf_mul_acc
module hmf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_lower,
    output hmf_pkg::t_result    o_res
);
    localparam int W = hmf_pkg::COUNT_WIDTH;

    hmf_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_sfield, n_sfield;
    logic [4:0] r_lpos, n_lpos;
    logic r_resp, n_resp, r_chk, n_chk, r_trl, n_trl;
    logic [W-1:0] r_target, n_target, r_seen, n_seen, r_left, n_left;
    logic [2:0] r_nm, n_nm;
    logic [3:0] r_vm, n_vm;
    logic [9:0] r_stat, n_stat;

    logic [W-1:0] acc_in, acc_out;
    logic acc_hex;
    logic [3:0] acc_d;
    logic [4:0] hv;
    logic [7:0] lb;
    logic [13:0] stat_x;
    logic [W-1:0] seen_inc;
    logic [2:0] nm_t;
    logic done, err;
    hmf_pkg::t_result res;

    hmf_mul_acc u_acc (.i_acc(acc_in), .i_hex(acc_hex), .i_digit(acc_d), .o_acc(acc_out));

    always_comb begin
        lb = hmf_pkg::to_lower(i_byte);
        hv = hmf_pkg::hex_value(i_byte);
        seen_inc = (r_seen != hmf_pkg::CNT_MAX) ? r_seen + 1'b1 : r_seen;
        stat_x = {r_stat, 3'b0} + {r_stat, 1'b0} + 14'(i_byte[3:0]);
        acc_hex = (r_phase == hmf_pkg::PH_CSIZE);
        acc_in = acc_hex ? r_left : r_target;
        acc_d = acc_hex ? hv[3:0] : i_byte[3:0];
    end

    always_comb begin
        n_phase = r_phase; n_sfield = r_sfield; n_lpos = r_lpos; n_resp = r_resp;
        n_chk = r_chk; n_trl = r_trl; n_target = r_target; n_seen = r_seen;
        n_left = r_left; n_nm = r_nm; n_vm = r_vm; n_stat = r_stat;
        nm_t = r_nm;
        done = 1'b0; err = 1'b0;
        res.kind = hmf_pkg::K_SKIP;
        res.out_byte = i_byte;
        unique case (r_phase)
            hmf_pkg::PH_SKIP: begin
                if (i_byte == hmf_pkg::CH_CR || i_byte == hmf_pkg::CH_LF ||
                    i_byte == hmf_pkg::CH_SP || i_byte == 8'd0) begin
                end else if (lb >= "a" && lb <= "z") begin
                    n_phase = hmf_pkg::PH_START; n_sfield = 2'd0;
                    res.kind = hmf_pkg::K_FIRST;
                    n_vm = (i_byte == "H") ? 4'd1 : 4'd15;
                end else begin
                    n_phase = hmf_pkg::PH_IGNORE;
                end
            end
            hmf_pkg::PH_START: begin
                if (i_byte == hmf_pkg::CH_LF) begin
                    if (r_sfield == 2'd3 && (r_resp || r_lpos >= 5'd8)) begin
                        n_phase = hmf_pkg::PH_HBEGIN; n_lpos = '0; n_nm = 3'd7; n_vm = '0;
                    end else err = 1'b1;
                end else if (i_byte == hmf_pkg::CH_CR) begin
                end else if (r_sfield == 2'd0) begin
                    if (i_byte == hmf_pkg::CH_SP) begin
                        n_sfield = 2'd1; n_vm = '0; n_lpos = '0;
                    end else begin
                        res.kind = hmf_pkg::K_FIRST;
                        if (r_vm < 4'd4) begin
                            if (i_byte == hmf_pkg::http_char(r_vm)) begin
                                n_vm = r_vm + 4'd1;
                                if (r_vm == 4'd3) n_resp = 1'b1;
                            end else n_vm = 4'd15;
                        end
                    end
                end else if (r_sfield == 2'd1) begin
                    if (i_byte == hmf_pkg::CH_SP) begin
                        n_sfield = 2'd3; n_lpos = '0;
                    end else if (!r_resp && i_byte == "?") n_sfield = 2'd2;
                    else begin
                        res.kind = hmf_pkg::K_SECOND;
                        if (r_resp) begin
                            if (r_vm == 4'd0 && hmf_pkg::is_digit(i_byte))
                                n_stat = (stat_x > 14'd999) ? 10'd999 : stat_x[9:0];
                            else n_vm = 4'd1;
                        end
                    end
                end else if (r_sfield == 2'd2) begin
                    if (i_byte == hmf_pkg::CH_SP) begin
                        n_sfield = 2'd3; n_lpos = '0;
                    end else res.kind = hmf_pkg::K_QUERY;
                end else begin
                    res.kind = hmf_pkg::K_THIRD;
                    if (r_lpos < 5'd31) n_lpos = r_lpos + 5'd1;
                end
            end
            hmf_pkg::PH_IGNORE: begin
                if (i_byte == hmf_pkg::CH_LF) begin
                    n_phase = hmf_pkg::PH_HBEGIN; n_lpos = '0; n_nm = 3'd7; n_vm = '0;
                end
            end
            hmf_pkg::PH_HBEGIN, hmf_pkg::PH_HNAME: begin
                if (i_byte == hmf_pkg::CH_LF) begin
                    if (r_phase == hmf_pkg::PH_HBEGIN) begin
                        if (r_target > r_seen) n_phase = hmf_pkg::PH_BODY;
                        else if (r_chk && r_target == '0) begin
                            n_phase = hmf_pkg::PH_CSIZE; n_lpos = '0; n_vm = '0;
                            n_left = '0;
                        end else done = 1'b1;
                    end else err = 1'b1;
                end else if (i_byte == hmf_pkg::CH_CR) begin
                end else if (i_byte == ":") begin
                    nm_t[0] = r_nm[0] && r_lpos == hmf_pkg::LEN_CL;
                    nm_t[1] = r_nm[1] && r_lpos == hmf_pkg::LEN_TE;
                    nm_t[2] = r_nm[2] && r_lpos == hmf_pkg::LEN_TR;
                    n_nm = nm_t;
                    if (nm_t[0]) n_target = '0;
                    if (nm_t[2]) begin n_chk = 1'b1; n_trl = 1'b1; end
                    n_vm = '0;
                    n_phase = hmf_pkg::PH_HCOLON;
                end else begin
                    res.kind = hmf_pkg::K_HNAME;
                    res.out_byte = i_lower ? lb : i_byte;
                    nm_t[0] = r_nm[0] && r_lpos < hmf_pkg::LEN_CL &&
                              lb == hmf_pkg::name_char(2'd0, r_lpos);
                    nm_t[1] = r_nm[1] && r_lpos < hmf_pkg::LEN_TE &&
                              lb == hmf_pkg::name_char(2'd1, r_lpos);
                    nm_t[2] = r_nm[2] && r_lpos < hmf_pkg::LEN_TR &&
                              lb == hmf_pkg::name_char(2'd2, r_lpos);
                    n_nm = nm_t;
                    if (r_lpos < 5'd31) n_lpos = r_lpos + 5'd1;
                    n_phase = hmf_pkg::PH_HNAME;
                end
            end
            hmf_pkg::PH_HCOLON, hmf_pkg::PH_HVALUE: begin
                if (i_byte == hmf_pkg::CH_LF) begin
                    n_phase = hmf_pkg::PH_HBEGIN; n_lpos = '0; n_nm = 3'd7; n_vm = '0;
                end else if (i_byte == hmf_pkg::CH_CR) begin
                end else if (r_phase == hmf_pkg::PH_HCOLON && i_byte == hmf_pkg::CH_SP) begin
                    n_phase = hmf_pkg::PH_HVALUE;
                end else begin
                    res.kind = hmf_pkg::K_HVALUE;
                    n_phase = hmf_pkg::PH_HVALUE;
                    if (r_nm[0]) begin
                        if (r_vm == 4'd0 && hmf_pkg::is_blank(i_byte)) begin
                        end else if (r_vm == 4'd0 && i_byte == "+") n_vm = 4'd3;
                        else if (r_vm != 4'd2 && hmf_pkg::is_digit(i_byte)) begin
                            n_target = acc_out; n_vm = 4'd1;
                        end else n_vm = 4'd2;
                    end else if (r_nm[1]) begin
                        if (r_vm < 4'd7) begin
                            if (i_byte == hmf_pkg::chunked_char(r_vm)) begin
                                n_vm = r_vm + 4'd1;
                                if (r_vm == 4'd6) n_chk = 1'b1;
                            end else n_vm = 4'd15;
                        end
                    end
                end
            end
            hmf_pkg::PH_BODY: begin
                res.kind = hmf_pkg::K_BODY;
                n_seen = seen_inc;
                if (seen_inc >= r_target) done = 1'b1;
            end
            hmf_pkg::PH_CSIZE: begin
                res.kind = hmf_pkg::K_CHUNK;
                if (i_byte == hmf_pkg::CH_LF) begin
                    if (r_lpos == '0) begin
                    end else if (r_left == '0) begin
                        n_target = r_seen; n_chk = 1'b0;
                        if (r_trl) begin
                            n_trl = 1'b0; n_phase = hmf_pkg::PH_HBEGIN; n_lpos = '0;
                            n_nm = 3'd7; n_vm = '0;
                        end else n_phase = hmf_pkg::PH_CTAIL;
                    end else n_phase = hmf_pkg::PH_CDATA;
                end else if (i_byte != hmf_pkg::CH_CR) begin
                    n_lpos = 5'd1;
                    // leading sign and 0x prefix handled before the digit path
                    if (r_vm == 4'd0 && hmf_pkg::is_blank(i_byte)) begin
                    end else if (r_vm == 4'd0 && i_byte == "+") n_vm = 4'd1;
                    else if (r_vm == 4'd0 && i_byte == "-") err = 1'b1;
                    else if ((r_vm == 4'd0 || r_vm == 4'd1) && i_byte == "0") n_vm = 4'd2;
                    else if (r_vm == 4'd2 && (i_byte == "x" || i_byte == "X")) n_vm = 4'd5;
                    else if (r_vm == 4'd4 || r_vm > 4'd5) begin
                    end else if (hv[4] == 1'b0) begin
                        n_left = acc_out; n_vm = 4'd3;
                    end else n_vm = 4'd4;
                end
            end
            hmf_pkg::PH_CDATA: begin
                res.kind = hmf_pkg::K_BODY;
                n_seen = seen_inc;
                if (r_left != '0) n_left = r_left - 1'b1;
                if (r_left <= W'(1)) n_phase = hmf_pkg::PH_CDEND;
            end
            hmf_pkg::PH_CDEND: begin
                res.kind = hmf_pkg::K_CHUNK;
                if (i_byte == hmf_pkg::CH_LF) begin
                    n_phase = hmf_pkg::PH_CSIZE; n_lpos = '0; n_vm = '0; n_left = '0;
                end
            end
            hmf_pkg::PH_CTAIL: begin
                res.kind = hmf_pkg::K_CHUNK;
                if (i_byte == hmf_pkg::CH_LF) done = 1'b1;
            end
            default: n_phase = hmf_pkg::PH_SKIP;
        endcase
        res.is_response = n_resp;
        res.status_code = n_stat;
        res.body_count = 40'(n_seen);
        res.message_done = done;
        res.error_flag = err;
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && (done || err))) begin
            r_phase <= hmf_pkg::PH_SKIP; r_sfield <= '0; r_lpos <= '0; r_resp <= 1'b0;
            r_chk <= 1'b0; r_trl <= 1'b0; r_target <= '0; r_seen <= '0; r_left <= '0;
            r_nm <= 3'd7; r_vm <= '0; r_stat <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_sfield <= n_sfield; r_lpos <= n_lpos; r_resp <= n_resp;
            r_chk <= n_chk; r_trl <= n_trl; r_target <= n_target; r_seen <= n_seen;
            r_left <= n_left; r_nm <= n_nm; r_vm <= n_vm; r_stat <= n_stat;
        end
    end

    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(done && err)) else $error("done and error together");
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (done || err) |=> r_phase == hmf_pkg::PH_SKIP && r_seen == '0)
        else $error("state not cleared after message end");
    a_body_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hmf_pkg::PH_BODY |-> res.kind == hmf_pkg::K_BODY)
        else $error("body byte mistagged");
endmodule

### rtl/core/http1_message_framer.sv
// http1_message_framer: top level, input register, parser, output skid stage
// depends on hmf_pkg, hmf_parser
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata: data_byte[7:0]
// m_axis   out  m_axis_tvalid/tready      tdata: kind, out_byte, is_response, ...
// cfg      in   i_cfg_valid/o_cfg_ready   i_cfg_data: lowercase_header_names
//
// one byte per cycle unless stalled; input register, then result or skid register
// parse state updates from the registered byte on each parser step
// reset is synchronous active low and clears all control state
// the input register stalls only when both the result and skid registers are full
module http1_message_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[3:0], out_byte[11:4], is_response[12], status_code[22:13],
    // body_count[62:23], message_done[63], error_flag[64], zeros[71:65]
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    logic r_lower;
    logic r_in_v;
    logic [7:0] r_in_b;
    logic r_out_v, r_skid_v;
    hmf_pkg::t_result r_out, r_skid, res;
    logic step, out_free;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lower <= 1'b0;
        else if (i_cfg_valid) r_lower <= i_cfg_data;
    end

    // result slot free when the skid register is empty
    assign out_free = !r_skid_v;
    assign step = r_in_v && out_free;
    assign s_axis_tready = !r_in_v || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_v <= 1'b0;
        else if (s_axis_tready) r_in_v <= s_axis_tvalid;
        if (s_axis_tready && s_axis_tvalid) r_in_b <= s_axis_tdata;
    end

    hmf_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(r_in_b),
        .i_lower(r_lower), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out_v <= 1'b1; r_skid_v <= 1'b0;
                end else r_out_v <= step;
            end else if (step) r_skid_v <= 1'b1;
        end
        if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) r_out <= r_skid;
            else if (step) r_out <= res;
        end else if (step) r_skid <= res;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {7'd0, r_out.error_flag, r_out.message_done, r_out.body_count,
                           r_out.status_code, r_out.is_response, r_out.out_byte, r_out.kind};

    a_skid_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid holds data with empty output");
    a_no_step_when_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !step) else $error("overrun of result stage");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !m_axis_tready |=> r_out_v) else $error("result dropped");
endmodule

### tb/sv/hmf_checker.sv
// hmf_checker: watches the byte, result and config channels of the framer,
// predicts each result from its own parser model and compares field by field
// depends on hmf_pkg
`timescale 1ns / 100ps

module hmf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] SAT = (64'd1 << 40) - 64'd1;

    string hdr_word [3] = '{"content-length", "transfer-encoding", "trailer"};
    string word_http    = "HTTP";
    string word_chunked = "chunked";

    hmf_pkg::t_result expected_results [$];

    logic            lc_mode;
    hmf_pkg::t_phase ph;
    logic [1:0]      sfield;
    logic [4:0]      lpos;
    logic            resp, chunked, trailer;
    logic [39:0]     target, seen, left;
    logic [2:0]      nmatch;
    logic [3:0]      vmatch;
    logic [9:0]      status;

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    endfunction

    function automatic logic digit(input logic [7:0] b);
        return b >= 8'd48 && b <= 8'd57;
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return b == 8'd32 || b == 8'd9 || b == 8'd11 || b == 8'd12;
    endfunction

    function automatic logic [39:0] sat_acc(input logic [63:0] v, input int base,
                                            input int d);
        if (v > (SAT - d) / base) return SAT[39:0];
        return 40'(v * base + d);
    endfunction

    function automatic int hexval(input logic [7:0] b);
        logic [7:0] l;
        l = lower(b);
        if (digit(b)) return b - 8'd48;
        if (l >= 8'd97 && l <= 8'd102) return l - 8'd97 + 10;
        return 16;
    endfunction

    task automatic clear_parse();
        ph = hmf_pkg::PH_SKIP; sfield = 0; lpos = 0; resp = 0; chunked = 0; trailer = 0;
        target = 0; seen = 0; left = 0; nmatch = 3'b111; vmatch = 0; status = 0;
    endtask

    task automatic header_line();
        ph = hmf_pkg::PH_HBEGIN; lpos = 0; nmatch = 3'b111; vmatch = 0;
    endtask

    task automatic http_match(input logic [7:0] b);
        if (vmatch < 4) begin
            if (b == word_http[vmatch]) begin
                vmatch++;
                if (vmatch == 4) resp = 1;
            end else begin
                vmatch = 15;
            end
        end
    endtask

    task automatic bump_seen();
        if (seen != SAT[39:0]) seen++;
    endtask

    // returns 1 on a framing error in the chunk size line
    function automatic logic size_byte(input logic [7:0] b);
        int h;
        logic accum;
        h = hexval(b);
        lpos = 1;
        accum = 0;
        case (vmatch)
            4'd0: begin
                if (blank(b)) return 0;
                if (b == "+") begin vmatch = 1; return 0; end
                if (b == "-") return 1;
                if (b == "0") begin vmatch = 2; return 0; end
                accum = 1;
            end
            4'd1: begin
                if (b == "0") begin vmatch = 2; return 0; end
                accum = 1;
            end
            4'd2: begin
                if (b == "x" || b == "X") begin vmatch = 5; return 0; end
                accum = 1;
            end
            4'd3, 4'd5: accum = 1;
            default: accum = 0;
        endcase
        if (accum) begin
            if (h < 16) begin
                left = sat_acc(left, 16, h);
                vmatch = 3;
            end else begin
                vmatch = 4;
            end
        end
        return 0;
    endfunction

    task automatic predict_byte(input logic [7:0] b, output hmf_pkg::t_result r);
        logic [7:0] ob, l;
        logic [3:0] kind;
        logic       done, err;
        int         v;
        ob = b; kind = hmf_pkg::K_SKIP; done = 0; err = 0; l = lower(b);
        case (ph)
            hmf_pkg::PH_SKIP: begin
                if (!(b == hmf_pkg::CH_CR || b == hmf_pkg::CH_LF || b == hmf_pkg::CH_SP ||
                      b == 8'd0)) begin
                    if (l >= 8'd97 && l <= 8'd122) begin
                        ph = hmf_pkg::PH_START; sfield = 0; vmatch = 0;
                        kind = hmf_pkg::K_FIRST;
                        http_match(b);
                    end else begin
                        ph = hmf_pkg::PH_IGNORE;
                    end
                end
            end
            hmf_pkg::PH_START: begin
                if (b == hmf_pkg::CH_LF) begin
                    if (sfield == 3 && (resp || lpos >= 8)) header_line();
                    else err = 1;
                end else if (b == hmf_pkg::CH_CR) begin
                end else if (sfield == 0) begin
                    if (b == hmf_pkg::CH_SP) begin sfield = 1; vmatch = 0; lpos = 0; end
                    else begin kind = hmf_pkg::K_FIRST; http_match(b); end
                end else if (sfield == 1) begin
                    if (b == hmf_pkg::CH_SP) begin sfield = 3; lpos = 0; end
                    else if (!resp && b == "?") sfield = 2;
                    else begin
                        kind = hmf_pkg::K_SECOND;
                        if (resp) begin
                            if (vmatch == 0 && digit(b)) begin
                                v = status * 10 + (b - 8'd48);
                                status = (v > 999) ? 10'd999 : 10'(v);
                            end else begin
                                vmatch = 1;
                            end
                        end
                    end
                end else if (sfield == 2) begin
                    if (b == hmf_pkg::CH_SP) begin sfield = 3; lpos = 0; end
                    else kind = hmf_pkg::K_QUERY;
                end else begin
                    kind = hmf_pkg::K_THIRD;
                    if (lpos < 31) lpos++;
                end
            end
            hmf_pkg::PH_IGNORE: if (b == hmf_pkg::CH_LF) header_line();
            hmf_pkg::PH_HBEGIN, hmf_pkg::PH_HNAME: begin
                if (b == hmf_pkg::CH_LF) begin
                    if (ph == hmf_pkg::PH_HBEGIN) begin
                        if (target > seen) ph = hmf_pkg::PH_BODY;
                        else if (chunked && target == 0) begin
                            ph = hmf_pkg::PH_CSIZE; lpos = 0; vmatch = 0; left = 0;
                        end else done = 1;
                    end else err = 1;
                end else if (b == hmf_pkg::CH_CR) begin
                end else if (b == ":") begin
                    for (int c = 0; c < 3; c++)
                        if (lpos != hdr_word[c].len()) nmatch[c] = 0;
                    if (nmatch[0]) target = 0;
                    if (nmatch[2]) begin chunked = 1; trailer = 1; end
                    vmatch = 0;
                    ph = hmf_pkg::PH_HCOLON;
                end else begin
                    kind = hmf_pkg::K_HNAME;
                    for (int c = 0; c < 3; c++)
                        if (nmatch[c] && !(lpos < hdr_word[c].len() && l == hdr_word[c][lpos]))
                            nmatch[c] = 0;
                    if (lpos < 31) lpos++;
                    ph = hmf_pkg::PH_HNAME;
                    ob = lc_mode ? l : b;
                end
            end
            hmf_pkg::PH_HCOLON, hmf_pkg::PH_HVALUE: begin
                if (b == hmf_pkg::CH_LF) header_line();
                else if (b == hmf_pkg::CH_CR) begin
                end else if (ph == hmf_pkg::PH_HCOLON && b == hmf_pkg::CH_SP)
                    ph = hmf_pkg::PH_HVALUE;
                else begin
                    kind = hmf_pkg::K_HVALUE;
                    if (nmatch[0]) begin
                        if (vmatch == 0 && blank(b)) begin
                        end else if (vmatch == 0 && b == "+") vmatch = 3;
                        else if (vmatch != 2 && digit(b)) begin
                            target = sat_acc(target, 10, b - 8'd48);
                            vmatch = 1;
                        end else vmatch = 2;
                    end else if (nmatch[1]) begin
                        if (vmatch < 7) begin
                            if (b == word_chunked[vmatch]) begin
                                vmatch++;
                                if (vmatch == 7) chunked = 1;
                            end else vmatch = 15;
                        end
                    end
                    ph = hmf_pkg::PH_HVALUE;
                end
            end
            hmf_pkg::PH_BODY: begin
                kind = hmf_pkg::K_BODY; bump_seen();
                if (seen >= target) done = 1;
            end
            hmf_pkg::PH_CSIZE: begin
                kind = hmf_pkg::K_CHUNK;
                if (b == hmf_pkg::CH_LF) begin
                    if (lpos == 0) begin
                    end else if (left == 0) begin
                        // last chunk
                        target = seen; chunked = 0;
                        if (trailer) begin trailer = 0; header_line(); end
                        else ph = hmf_pkg::PH_CTAIL;
                    end else ph = hmf_pkg::PH_CDATA;
                end else if (b != hmf_pkg::CH_CR) begin
                    err = size_byte(b);
                end
            end
            hmf_pkg::PH_CDATA: begin
                kind = hmf_pkg::K_BODY; bump_seen();
                if (left != 0) left--;
                if (left == 0) ph = hmf_pkg::PH_CDEND;
            end
            hmf_pkg::PH_CDEND: begin
                kind = hmf_pkg::K_CHUNK;
                if (b == hmf_pkg::CH_LF) begin
                    ph = hmf_pkg::PH_CSIZE; lpos = 0; vmatch = 0; left = 0;
                end
            end
            hmf_pkg::PH_CTAIL: begin
                kind = hmf_pkg::K_CHUNK;
                if (b == hmf_pkg::CH_LF) done = 1;
            end
            default: ph = hmf_pkg::PH_SKIP;
        endcase
        r.kind = kind; r.out_byte = ob; r.is_response = resp; r.status_code = status;
        r.body_count = seen; r.message_done = done; r.error_flag = err;
        if (done || err) clear_parse();
    endtask

    always @(posedge i_clk) begin
        hmf_pkg::t_result exp_r, got;
        if (!i_rst_n) begin
            lc_mode <= 0;
            clear_parse();
            expected_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) lc_mode <= i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata, exp_r);
                expected_results.push_back(exp_r);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = m_axis_tdata[3:0];
                got.out_byte     = m_axis_tdata[11:4];
                got.is_response  = m_axis_tdata[12];
                got.status_code  = m_axis_tdata[22:13];
                got.body_count   = m_axis_tdata[62:23];
                got.message_done = m_axis_tdata[63];
                got.error_flag   = m_axis_tdata[64];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transaction: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r || m_axis_tdata[71:65] !== 7'd0) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: kind %0d/%0d byte %h/%h resp %b/%b ",
                                      "status %0d/%0d count %0d/%0d done %b/%b err %b/%b"},
                                     exp_r.kind, got.kind, exp_r.out_byte, got.out_byte,
                                     exp_r.is_response, got.is_response,
                                     exp_r.status_code, got.status_code,
                                     exp_r.body_count, got.body_count,
                                     exp_r.message_done, got.message_done,
                                     exp_r.error_flag, got.error_flag);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

### tb/sv/tb_http1_message_framer.sv
// tb_http1_message_framer: drives http messages, broken messages and noise
// into the framer with random gaps and stalls; depends on hmf_checker, the rtl
`timescale 1ns / 100ps

module tb_http1_message_framer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    int          fail_count;
    int          pending;

    logic [7:0] msg_bytes [$];
    int         burst_left;
    int         bytes_sent;

    http1_message_framer dut (.*);

    hmf_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stalls: one of four ready patterns, picked at random
    initial begin
        int cyc, mode;
        cyc = 0; mode = 0;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready = 1;
                1: m_axis_tready = $urandom_range(0, 1);
                2: m_axis_tready = (cyc % 4 == 0);
                default: m_axis_tready = ($urandom_range(0, 7) != 0);
            endcase
            cyc++;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid = 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1;
        s_axis_tdata = b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    task automatic flush_msg();
        while (msg_bytes.size() != 0) send_byte(msg_bytes.pop_front());
        s_axis_tvalid = 0;
    endtask

    task automatic write_mode(input logic m);
        s_axis_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_data = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic string rand_word(input int n, input logic mixed_case);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            byte c;
            c = 8'(97 + $urandom_range(0, 25));
            if (mixed_case && $urandom_range(0, 1)) c = c - 32;
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= 97 && r[i] <= 122 && $urandom_range(0, 1)) r[i] = r[i] - 32;
        return r;
    endfunction

    // a well-formed message with random content
    task automatic build_message();
        int body_kind, n, nh, size;
        string eol;
        eol = $urandom_range(0, 3) ? "\r\n" : "\n";
        if ($urandom_range(0, 2) == 0) begin
            put_str($sformatf("HTTP/1.%0d %0d %s%s", $urandom_range(0, 1),
                              $urandom_range(0, 9999), rand_word($urandom_range(0, 6), 1),
                              eol));
        end else begin
            put_str({rand_word($urandom_range(1, 7), 1), " /",
                     rand_word($urandom_range(0, 8), 1)});
            if ($urandom_range(0, 1)) put_str({"?", rand_word($urandom_range(0, 6), 1)});
            put_str({" HTTP/1.1", eol});
        end
        nh = $urandom_range(0, 3);
        for (int i = 0; i < nh; i++)
            put_str({rand_word($urandom_range(1, 12), 1), ":",
                     $urandom_range(0, 1) ? " " : "", rand_word($urandom_range(0, 8), 1),
                     eol});
        body_kind = $urandom_range(0, 3);
        if (body_kind == 1) begin
            n = $urandom_range(0, 20);
            put_str({mix_case("content-length"), ":", $urandom_range(0, 1) ? " \t" : "",
                     $urandom_range(0, 3) ? "" : "+", $sformatf("%0d", n), eol, eol});
            repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (body_kind >= 2) begin
            if (body_kind == 2) put_str({mix_case("transfer-encoding"), ": chunked", eol});
            else put_str({mix_case("trailer"), ": x-sum", eol});
            put_str(eol);
            repeat ($urandom_range(1, 3)) begin
                size = $urandom_range(1, 20);
                if ($urandom_range(0, 5) == 0) put_str(eol);
                case ($urandom_range(0, 3))
                    0: put_str($sformatf("%0x", size));
                    1: put_str($sformatf("%0X", size));
                    2: put_str($sformatf("0x%0x", size));
                    default: put_str($sformatf(" +0%0x", size));
                endcase
                if ($urandom_range(0, 3) == 0) put_str(";ext=1");
                put_str(eol);
                repeat (size) msg_bytes.push_back(8'($urandom_range(0, 255)));
                put_str(eol);
            end
            put_str({"0", eol});
            if (body_kind == 3) put_str({"X-Sum: ", rand_word(3, 1), eol});
            put_str(eol);
        end else begin
            put_str(eol);
        end
    endtask

    // noise excludes hex digits so that it can never start a huge chunk
    task automatic build_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 10)) begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= 48 && b <= 57) || (b >= 65 && b <= 70) || (b >= 97 && b <= 102));
            msg_bytes.push_back(b);
        end
        if ($urandom_range(0, 1)) msg_bytes.push_back(hmf_pkg::CH_LF);
    endtask

    initial begin
        int cut, next_cfg;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        i_cfg_valid = 0; i_cfg_data = 0;
        burst_left = 0; bytes_sent = 0;
        i_rst_n = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        write_mode(0);
        msg_bytes.push_back(8'd0);
        put_str(" \r\nGET /a?q=1 HTTP/1.1\r\nHost: x\r\n\r\n");
        put_str("HTTP/1.1 12345 Big\r\n\r\n");
        put_str("HTTP/1.0 2x3 Odd\r\nContent-Length:  +3\r\n\r\nabc");
        put_str("1odd start\r\nA: b\r\n:v\r\n\r\n");
        put_str("GET /\r\n");
        put_str("GET / HTTP/1\r\n");
        put_str("GET / HTTP/1.1\r\nNoColon\r\n");
        put_str("POST /u HTTP/1.1\r\nContent-Length: -5\r\n\r\n");
        put_str("POST /c HTTP/1.1\r\nTRANSFER-encoding: chunked\r\n\r\n\r\n0x1A\r\n");
        repeat (26) msg_bytes.push_back(8'($urandom_range(128, 255)));
        put_str("\r\n0\r\n\r\n");
        put_str("PUT /e HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n-1\r\n");
        put_str("GET /t HTTP/1.1\r\nTrailer: X\r\n\r\n +2;ext\r\nhi\r\n0\r\nX: 1\r\n\r\n");
        flush_msg();
        write_mode(1);
        put_str("zget /l HTTP/1.1\r\nCONTENT-Length:2\r\nMiXeD-Name: V\r\n\r\n");
        msg_bytes.push_back(8'hff); msg_bytes.push_back(8'h00);
        flush_msg();

        next_cfg = bytes_sent + 400;
        while (bytes_sent < 1950) begin
            case ($urandom_range(0, 9))
                0: build_noise();
                1: begin
                    // truncated at a random point, then a request whose header line has no colon
                    build_message();
                    cut = $urandom_range(1, msg_bytes.size());
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                    put_str("GET /r HTTP/1.1\r\nBroken\r\n");
                end
                default: build_message();
            endcase
            flush_msg();
            if (bytes_sent >= next_cfg) begin
                write_mode($urandom_range(0, 1));
                next_cfg = bytes_sent + 400;
            end
        end

        // saturating content length, the body never completes
        put_str("GET /z HTTP/1.1\r\nContent-Length: 99999999999999999999\r\n\r\n");
        repeat (6) msg_bytes.push_back(8'($urandom_range(0, 255)));
        flush_msg();

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/hmf_pkg.sv
rtl/core/hmf_mul_acc.sv
rtl/core/hmf_parser.sv
rtl/core/http1_message_framer.sv
tb/sv/hmf_checker.sv
tb/sv/tb_http1_message_framer.sv
